>>> src/mhc_pkg.sv
// Shared types and constants for the magnetometer heading calibrator.
// No dependencies.
`default_nettype none
package mhc_pkg;
   localparam int VEC_W = 45;
   localparam int ANG_W = 32;
   localparam int MAX_STEPS = 24;
   localparam logic signed [ANG_W-1:0] ANG_HALF_TURN = 32'sd117964800;
   localparam logic signed [ANG_W-1:0] ANG_BIAS = 32'sd471891968;
   localparam logic [13:0] TURN_TENTHS = 14'd3600;

   localparam logic [2:0] REG_SWAP = 3'd0;
   localparam logic [2:0] REG_NEGX = 3'd1;
   localparam logic [2:0] REG_NEGY = 3'd2;
   localparam logic [2:0] REG_SPAN = 3'd3;
   localparam logic [2:0] REG_OFFS = 3'd4;

   function automatic logic [25:0] atan_step(input logic [4:0] i);
      logic [25:0] r;
      case (i)
         5'd0: r = 26'd29491200;
         5'd1: r = 26'd17409672;
         5'd2: r = 26'd9198793;
         5'd3: r = 26'd4669451;
         5'd4: r = 26'd2343786;
         5'd5: r = 26'd1173036;
         5'd6: r = 26'd586661;
         5'd7: r = 26'd293348;
         5'd8: r = 26'd146676;
         5'd9: r = 26'd73339;
         5'd10: r = 26'd36669;
         5'd11: r = 26'd18335;
         5'd12: r = 26'd9167;
         5'd13: r = 26'd4584;
         5'd14: r = 26'd2292;
         5'd15: r = 26'd1146;
         5'd16: r = 26'd573;
         5'd17: r = 26'd286;
         5'd18: r = 26'd143;
         5'd19: r = 26'd72;
         5'd20: r = 26'd36;
         5'd21: r = 26'd18;
         5'd22: r = 26'd9;
         5'd23: r = 26'd4;
         default: r = 26'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

>>> src/mhc_cordic.sv
// Iterative vectoring CORDIC: normalize by one doubling per cycle, then one
// rotation per cycle. Depends on mhc_pkg.
`default_nettype none
module mhc_cordic #(
   parameter int STEPS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [mhc_pkg::VEC_W-1:0] im_in,
   input  wire logic signed [mhc_pkg::VEC_W-1:0] re_in,
   output logic done,
   output logic signed [mhc_pkg::ANG_W-1:0] angle
);
   localparam int NSTEP = (STEPS > mhc_pkg::MAX_STEPS) ? mhc_pkg::MAX_STEPS : STEPS;
   localparam logic [4:0] LAST = 5'(NSTEP - 1);
   localparam logic signed [mhc_pkg::VEC_W-1:0] LIM = 45'sd1099511627776;

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_NORM = 3'b010,
      C_ROT  = 3'b100
   } cstate_type;

   cstate_type state_ff, state_in;
   logic signed [mhc_pkg::VEC_W-1:0] re_ff, re_in2, im_ff, im_in2;
   logic signed [mhc_pkg::ANG_W-1:0] z_ff, z_in;
   logic [4:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic grow;
   logic signed [mhc_pkg::VEC_W-1:0] re_sh, im_sh;
   logic signed [mhc_pkg::ANG_W-1:0] at;

   assign grow = (im_ff < LIM) && (im_ff > -LIM) && (re_ff < LIM) && (re_ff > -LIM);
   assign re_sh = re_ff >>> cnt_ff;
   assign im_sh = im_ff >>> cnt_ff;
   assign at = mhc_pkg::ANG_W'(mhc_pkg::atan_step(cnt_ff));

   always_comb begin
      state_in = state_ff;
      re_in2 = re_ff;
      im_in2 = im_ff;
      z_in = z_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               re_in2 = re_in;
               im_in2 = im_in;
               z_in = '0;
               cnt_in = '0;
               if (re_in == '0 && im_in == '0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = C_NORM;
               end
            end
         end
         C_NORM: begin
            if (grow) begin
               re_in2 = re_ff <<< 1;
               im_in2 = im_ff <<< 1;
            end else begin
               if (re_ff < 0) begin
                  z_in = (im_ff >= 0) ? mhc_pkg::ANG_HALF_TURN : -mhc_pkg::ANG_HALF_TURN;
                  re_in2 = -re_ff;
                  im_in2 = -im_ff;
               end
               state_in = C_ROT;
            end
         end
         C_ROT: begin
            if (im_ff >= 0) begin
               re_in2 = re_ff + im_sh;
               im_in2 = im_ff - re_sh;
               z_in = z_ff + at;
            end else begin
               re_in2 = re_ff - im_sh;
               im_in2 = im_ff + re_sh;
               z_in = z_ff - at;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LAST) begin
               state_in = C_IDLE;
               done_in = 1'b1;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      re_ff <= re_in2;
      im_ff <= im_in2;
      z_ff <= z_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign angle = z_ff;
endmodule
`default_nettype wire

>>> src/magnetometer_heading_calibrator.sv
// Top level: stream ports, register file, min/max tracking and span
// equalization. Depends on mhc_pkg and mhc_cordic.
//
// One sample at a time. Each beat passes through the IDLE, MUL, ANGLE, WRAP and
// HOLD states; its length is set by the normalizing and rotation loops of the
// CORDIC unit and by the modulo steps in WRAP, and a zero vector skips both
// loops. The result sits in an output register, so the next sample is taken
// while it waits.
`default_nettype none
module magnetometer_heading_calibrator #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [31:0] req_tdata,   // raw_x, raw_y
   input  wire logic req_tuser,          // restart
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [47:0] rsp_tdata,        // heading_tenths, span_x, span_y, zero fill
   output logic rsp_tuser,               // calibrating
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [4:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MUL   = 5'b00010,
      S_ANGLE = 5'b00100,
      S_WRAP  = 5'b01000,
      S_HOLD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic swap_ff, negx_ff, negy_ff;
   logic [15:0] min_span_ff;
   logic signed [11:0] offs_ff;
   logic seen_ff;
   logic signed [16:0] x_ff, y_ff, minx_ff, maxx_ff, miny_ff, maxy_ff;
   logic signed [mhc_pkg::VEC_W-1:0] vx_ff, vy_ff;
   logic cal_ff;
   logic [13:0] q_ff, q_in;
   logic rsp_v_ff;
   logic [11:0] hd_ff;
   logic [15:0] sx_out_ff, sy_out_ff;
   logic rcal_ff;
   logic start_ff;
   logic cord_start;
   logic cord_done;
   logic signed [mhc_pkg::ANG_W-1:0] angle;

   logic wr;
   logic signed [16:0] ax, ay, ox, oy;
   logic first;
   logic [16:0] spx, spy;
   logic calib;
   logic signed [18:0] cx, cy;
   logic signed [37:0] px, py;
   logic signed [mhc_pkg::ANG_W-1:0] t;
   logic out_free;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[4:2])
         mhc_pkg::REG_SWAP: csr_prdata = {31'd0, swap_ff};
         mhc_pkg::REG_NEGX: csr_prdata = {31'd0, negx_ff};
         mhc_pkg::REG_NEGY: csr_prdata = {31'd0, negy_ff};
         mhc_pkg::REG_SPAN: csr_prdata = {16'd0, min_span_ff};
         mhc_pkg::REG_OFFS: csr_prdata = {{20{offs_ff[11]}}, offs_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign ax = swap_ff ? 17'(signed'(req_tdata[31:16])) : 17'(signed'(req_tdata[15:0]));
   assign ay = swap_ff ? 17'(signed'(req_tdata[15:0])) : 17'(signed'(req_tdata[31:16]));
   assign ox = negx_ff ? -ax : ax;
   assign oy = negy_ff ? -ay : ay;
   assign first = !seen_ff || req_tuser;

   assign spx = 17'(maxx_ff - minx_ff);
   assign spy = 17'(maxy_ff - miny_ff);
   assign calib = (spx < {1'b0, min_span_ff}) || (spy < {1'b0, min_span_ff});
   assign cx = (19'(x_ff) <<< 1) - (19'(minx_ff) + 19'(maxx_ff));
   assign cy = (19'(y_ff) <<< 1) - (19'(miny_ff) + 19'(maxy_ff));
   assign px = 38'(cx) * 38'(signed'({1'b0, spy}));
   assign py = 38'(cy) * 38'(signed'({1'b0, spx}));

   assign t = angle + mhc_pkg::ANG_W'(signed'({offs_ff, 16'd0})) + mhc_pkg::ANG_BIAS;
   assign out_free = !rsp_v_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign cord_start = start_ff;

   always_comb begin
      state_in = state_ff;
      q_in = q_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_MUL;
         S_MUL: state_in = S_ANGLE;
         S_ANGLE: begin
            if (cord_done) begin
               q_in = t[29:16];
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            if (q_ff >= mhc_pkg::TURN_TENTHS) q_in = q_ff - mhc_pkg::TURN_TENTHS;
            else state_in = S_HOLD;
         end
         S_HOLD: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   mhc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cord_start),
      .im_in(vx_ff), .re_in(vy_ff), .done(cord_done), .angle(angle)
   );

   // the MUL state writes vx/vy, CORDIC samples them the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         swap_ff <= 1'b0;
         negx_ff <= 1'b0;
         negy_ff <= 1'b0;
         min_span_ff <= 16'd200;
         offs_ff <= '0;
         seen_ff <= 1'b0;
         minx_ff <= '0;
         maxx_ff <= '0;
         miny_ff <= '0;
         maxy_ff <= '0;
         rsp_v_ff <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == S_MUL);
         if (wr) begin
            case (csr_paddr[4:2])
               mhc_pkg::REG_SWAP: swap_ff <= csr_pwdata[0];
               mhc_pkg::REG_NEGX: negx_ff <= csr_pwdata[0];
               mhc_pkg::REG_NEGY: negy_ff <= csr_pwdata[0];
               mhc_pkg::REG_SPAN: min_span_ff <= csr_pwdata[15:0];
               mhc_pkg::REG_OFFS: offs_ff <= csr_pwdata[11:0];
               default: ;
            endcase
         end
         if (state_ff == S_IDLE && req_tvalid) begin
            seen_ff <= 1'b1;
            if (first) begin
               minx_ff <= ox;
               maxx_ff <= ox;
               miny_ff <= oy;
               maxy_ff <= oy;
            end else begin
               if (ox < minx_ff) minx_ff <= ox;
               if (ox > maxx_ff) maxx_ff <= ox;
               if (oy < miny_ff) miny_ff <= oy;
               if (oy > maxy_ff) maxy_ff <= oy;
            end
         end
         if (state_ff == S_HOLD && out_free) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
      end
      if (state_ff == S_IDLE) begin
         x_ff <= ox;
         y_ff <= oy;
      end
      if (state_ff == S_MUL) begin
         cal_ff <= calib;
         if (!calib && spx != '0 && spy != '0) begin
            vx_ff <= mhc_pkg::VEC_W'(px);
            vy_ff <= mhc_pkg::VEC_W'(py);
         end else begin
            vx_ff <= mhc_pkg::VEC_W'(x_ff);
            vy_ff <= mhc_pkg::VEC_W'(y_ff);
         end
      end
      q_ff <= q_in;
      if (state_ff == S_HOLD && out_free) begin
         hd_ff <= q_ff[11:0];
         rcal_ff <= cal_ff;
         sx_out_ff <= spx[16] ? 16'hFFFF : spx[15:0];
         sy_out_ff <= spy[16] ? 16'hFFFF : spy[15:0];
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = {4'd0, sy_out_ff, sx_out_ff, hd_ff};
   assign rsp_tuser = rcal_ff;
endmodule
`default_nettype wire

>>> verif/mhc_checker.sv
// Checker for the magnetometer heading calibrator: watches both stream channels,
// predicts each result from its own model of the block and compares field by field.
// Depends on mhc_pkg (register indexes) and the configuration beats seen on csr_*.
module mhc_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   input  wire logic req_tready,
   input  wire logic [31:0] req_tdata,   // raw_x, raw_y
   input  wire logic req_tuser,          // restart
   input  wire logic rsp_tvalid,
   input  wire logic rsp_tready,
   input  wire logic [47:0] rsp_tdata,   // heading_tenths, span_x, span_y, zero fill
   input  wire logic rsp_tuser,          // calibrating
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [4:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output int fail_count,
   output int pending,
   output int results_seen,
   output int calib_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = 16;
   localparam longint TENTH = 65536;
   localparam longint HALF = 1800 * TENTH;
   localparam longint FULL = 3600 * TENTH;
   localparam longint LIMIT = 64'sd1 << 40;

   typedef struct {
      logic [11:0] heading;
      logic        calibrating;
      logic [15:0] span_x;
      logic [15:0] span_y;
   } heading_type;

   const longint atan_tab[24] = '{29491200, 17409672, 9198793, 4669451, 2343786,
      1173036, 586661, 293348, 146676, 73339, 36669, 18335, 9167, 4584, 2292,
      1146, 573, 286, 143, 72, 36, 18, 9, 4};

   logic swap_q, negx_q, negy_q;
   logic [15:0] min_span_q;
   logic signed [11:0] offset_q;
   logic seen_q;
   int min_x, max_x, min_y, max_y;
   heading_type expected_q[$];

   function automatic longint angle_of(longint im, longint re);
      longint z, nre, nim;
      z = 0;
      if (im == 0 && re == 0) return 0;
      while ((im < 0 ? -im : im) < LIMIT && (re < 0 ? -re : re) < LIMIT) begin
         im = im * 2;
         re = re * 2;
      end
      if (re < 0) begin
         z = (im >= 0) ? HALF : -HALF;
         re = -re;
         im = -im;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (im >= 0) begin
            nre = re + (im >>> i);
            nim = im - (re >>> i);
            z += atan_tab[i];
         end else begin
            nre = re - (im >>> i);
            nim = im + (re >>> i);
            z -= atan_tab[i];
         end
         re = nre;
         im = nim;
      end
      return z;
   endfunction

   task automatic predict_heading(input logic [31:0] d, input logic rst);
      int x, y, sx, sy;
      longint vx, vy, t;
      heading_type e;
      x = swap_q ? int'($signed(d[31:16])) : int'($signed(d[15:0]));
      y = swap_q ? int'($signed(d[15:0])) : int'($signed(d[31:16]));
      if (negx_q) x = -x;
      if (negy_q) y = -y;
      if (!seen_q || rst) begin
         min_x = x; max_x = x; min_y = y; max_y = y;
      end else begin
         if (x < min_x) min_x = x;
         if (x > max_x) max_x = x;
         if (y < min_y) min_y = y;
         if (y > max_y) max_y = y;
      end
      seen_q = 1;
      sx = max_x - min_x;
      sy = max_y - min_y;
      e.calibrating = (sx < int'(min_span_q)) || (sy < int'(min_span_q));
      if (!e.calibrating && sx > 0 && sy > 0) begin
         vx = (2 * longint'(x) - (longint'(min_x) + max_x)) * sy;
         vy = (2 * longint'(y) - (longint'(min_y) + max_y)) * sx;
      end else begin
         vx = x;
         vy = y;
      end
      t = angle_of(vx, vy) + longint'(offset_q) * TENTH + 2 * FULL + TENTH / 2;
      e.heading = 12'((t >>> 16) % 3600);
      e.span_x = sx > 65535 ? 16'hFFFF : 16'(sx);
      e.span_y = sy > 65535 ? 16'hFFFF : 16'(sy);
      expected_q.push_back(e);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         swap_q <= 0; negx_q <= 0; negy_q <= 0;
         min_span_q <= 16'd200; offset_q <= '0;
         seen_q = 0;
         min_x = 0; max_x = 0; min_y = 0; max_y = 0;
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[4:2])
               mhc_pkg::REG_SWAP: swap_q <= csr_pwdata[0];
               mhc_pkg::REG_NEGX: negx_q <= csr_pwdata[0];
               mhc_pkg::REG_NEGY: negy_q <= csr_pwdata[0];
               mhc_pkg::REG_SPAN: min_span_q <= csr_pwdata[15:0];
               mhc_pkg::REG_OFFS: offset_q <= csr_pwdata[11:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            heading_type e, a;
            a.heading = rsp_tdata[11:0];
            a.span_x = rsp_tdata[27:12];
            a.span_y = rsp_tdata[43:28];
            a.calibrating = rsp_tuser;
            results_seen <= results_seen + 1;
            if (rsp_tuser) calib_seen <= calib_seen + 1;
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat %h", rsp_tdata);
            end else begin
               e = expected_q.pop_front();
               if (a.heading !== e.heading || a.calibrating !== e.calibrating ||
                   a.span_x !== e.span_x || a.span_y !== e.span_y) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp hdg %0d cal %0d sx %0d sy %0d, got %0d %0d %0d %0d",
                        e.heading, e.calibrating, e.span_x, e.span_y,
                        a.heading, a.calibrating, a.span_x, a.span_y);
               end
            end
         end
         if (req_tvalid && req_tready) predict_heading(req_tdata, req_tuser);
      end
      pending = expected_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      results_seen = 0;
      calib_seen = 0;
   end
endmodule

>>> verif/tb_magnetometer_heading_calibrator.sv
// Top of the heading calibrator testbench: clock, reset, register phases and stream
// stimulus with idling and back-pressure. Depends on mhc_pkg, mhc_checker and the RTL.
module tb_magnetometer_heading_calibrator;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [31:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tuser;
   logic [47:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int fail_count, pending, results_seen, calib_seen;
   int send_idle, recv_stall;
   int hold_cycles;
   longint cycle_count;

   magnetometer_heading_calibrator dut (.*);

   mhc_checker chk (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [15:0] x, input logic [15:0] y, input logic rst);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1; req_tdata <= {y, x}; req_tuser <= rst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic setup_regs(input logic sw, input logic nx, input logic ny,
                             input logic [15:0] ms, input logic [11:0] off);
      csr_write(mhc_pkg::REG_SWAP, 32'(sw));
      csr_write(mhc_pkg::REG_NEGX, 32'(nx));
      csr_write(mhc_pkg::REG_NEGY, 32'(ny));
      csr_write(mhc_pkg::REG_SPAN, 32'(ms));
      csr_write(mhc_pkg::REG_OFFS, 32'(off));
   endtask

   // circle-like sweep with random radius, center and noise; sometimes noise only
   task automatic random_run(input int n);
      int r, cx, cy, px, py;
      real a;
      r = int'($urandom_range(30000, 50));
      cx = int'($urandom_range(4000)) - 2000;
      cy = int'($urandom_range(4000)) - 2000;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) begin
            send_sample(16'($urandom), 16'($urandom), $urandom_range(19) == 0);
         end else begin
            a = $urandom_range(3599) * 3.14159265 / 1800.0;
            px = cx + int'(r * $cos(a)) + int'($urandom_range(20)) - 10;
            py = cy + int'(r * $sin(a) * 0.7) + int'($urandom_range(20)) - 10;
            if (px > 32767) px = 32767;
            if (px < -32768) px = -32768;
            if (py > 32767) py = 32767;
            if (py < -32768) py = -32768;
            send_sample(16'(px), 16'(py), i == 0);
         end
      end
   endtask

   initial begin
      reset = 1; cycle_count = 0; hold_cycles = 0;
      req_tvalid = 0; req_tdata = 0; req_tuser = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      send_idle = 0; recv_stall = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, extremes, zero vector, full span, restart
      send_sample(16'h0000, 16'h0000, 1);
      send_sample(16'h8000, 16'h8000, 0);
      send_sample(16'h7FFF, 16'h7FFF, 0);
      send_sample(16'h8000, 16'h7FFF, 0);
      send_sample(16'h7FFF, 16'h8000, 0);
      send_sample(16'h0000, 16'h0000, 0);
      send_sample(16'h0064, 16'hFF9C, 1);
      send_sample(16'hFFFF, 16'h5555, 0);
      send_sample(16'hAAAA, 16'h0001, 0);
      drain_results();
      setup_regs(1, 1, 1, 16'd0, 12'sd1800);
      send_sample(16'h8000, 16'h8000, 1);
      send_sample(16'h8000, 16'h0005, 0);
      send_sample(16'h8000, 16'h7FFF, 0);
      send_sample(16'h7FFF, 16'h0000, 0);
      send_sample(16'h0000, 16'h0000, 1);
      drain_results();
      setup_regs(0, 1, 0, 16'hFFFF, 12'h800);
      send_sample(16'h8000, 16'h1234, 1);
      send_sample(16'h7FFF, 16'h4321, 0);
      send_sample(16'h0000, 16'h0000, 0);
      drain_results();
      setup_regs(0, 0, 1, 16'd1, 12'h7FF);
      send_sample(16'h0010, 16'h0010, 1);
      send_sample(16'h0000, 16'hFFF0, 0);
      send_sample(16'h0000, 16'h0000, 0);
      drain_results();

      // random phases over idling patterns and settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 71; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 71; end
            default: begin send_idle = 20; recv_stall = 20; end
         endcase
         setup_regs(1'($urandom), 1'($urandom), 1'($urandom),
                    ph == 7 ? 16'hFFFF : 16'($urandom_range(3000)),
                    ph == 6 ? 12'h838 : 12'(int'($urandom_range(3600)) - 1800));
         if (ph == 2) hold_cycles = 2000;
         for (int k = 0; k < 4; k++) random_run(40);
         drain_results();
      end

      $display("Covered %0d result beats (%0d while calibrating) across 12 register settings",
               results_seen, calib_seen);
      $display("with directed extremes, idle/stall phases and one long output hold-off.");
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

>>> magnetometer_heading_calibrator.f
src/mhc_pkg.sv
src/mhc_cordic.sv
src/magnetometer_heading_calibrator.sv
verif/mhc_checker.sv
verif/tb_magnetometer_heading_calibrator.sv
